// ===== design/qalu_pkg.sv =====
// Shared types and codes for the Q24.8 fixed-point ALU.
// No dependencies; imported by every module of the block.
package qalu_pkg;

  localparam int IO_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LE, OP_GT, OP_GE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                    op;
    logic signed [IO_BITS-1:0]  operand_a;
    logic signed [IO_BITS-1:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0]  result_value;
    logic                       compare_true;
    status_t                    status;
  } out_item_t;

endpackage

// ===== design/fixed_point_q24_8_alu_unit.sv =====
// Q24.8 fixed-point ALU top level. Pipeline: input register, one stage per
// quotient bit of the divider, then the output register. Throughput one item
// per cycle; the whole pipeline advances together and holds while a result
// is stalled.
// Synchronous reset clears all valid bits; payload registers are not reset.
module fixed_point_q24_8_alu_unit #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qalu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qalu_pkg::out_item_t out_data
);
  import qalu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NQ = WORD_BITS + FRAC_BITS;

  typedef struct packed {
    opcode_t      op;
    logic [W-1:0] r;
    logic         cmp;
    logic         neg;
    logic         bz;
  } side_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // operand fitting and the operations that need neither multiplier nor divider
  logic signed [W-1:0] a_in;
  logic signed [W-1:0] b_in;
  logic [W-1:0]        mag_a_next;
  logic [W-1:0]        mag_b_next;
  side_t               sb_next;

  always_comb begin
    a_in = W'(in_data.operand_a);
    b_in = W'(in_data.operand_b);
    mag_a_next = a_in[W-1] ? (W'(0) - a_in) : a_in;
    mag_b_next = b_in[W-1] ? (W'(0) - b_in) : b_in;
    sb_next.op  = in_data.op;
    sb_next.r   = '0;
    sb_next.cmp = 1'b0;
    sb_next.neg = a_in[W-1] ^ b_in[W-1];
    sb_next.bz  = b_in == '0;
    unique case (in_data.op)
      OP_ADD:     sb_next.r = a_in + b_in;
      OP_SUB:     sb_next.r = a_in - b_in;
      OP_MUL:     sb_next.r = '0;
      OP_DIV:     sb_next.r = '0;
      OP_LT:      sb_next.cmp = a_in < b_in;
      OP_LE:      sb_next.cmp = !(b_in < a_in);
      OP_GT:      sb_next.cmp = b_in < a_in;
      OP_GE:      sb_next.cmp = !(a_in < b_in);
      OP_EQ:      sb_next.cmp = a_in == b_in;
      OP_NE:      sb_next.cmp = a_in != b_in;
      OP_MIN:     sb_next.r = (a_in < b_in) ? a_in : b_in;
      OP_MAX:     sb_next.r = (b_in < a_in) ? a_in : b_in;
      OP_INC:     sb_next.r = a_in + W'(1);
      OP_DEC:     sb_next.r = a_in - W'(1);
      OP_TOINT:   sb_next.r = a_in >>> FRAC_BITS;
      OP_FROMINT: sb_next.r = a_in << FRAC_BITS;
      default:    sb_next.r = '0;
    endcase
  end

  // input register and sideband line running beside the divider
  logic         v  [NQ+1];
  side_t        sb [NQ+1];
  logic [W-1:0] mag_a1;
  logic [W-1:0] mag_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NQ; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i <= NQ; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0]  <= sb_next;
      mag_a1 <= mag_a_next;
      mag_b1 <= mag_b_next;
      for (int i = 1; i <= NQ; i++) sb[i] <= sb[i-1];
    end
  end

  // multiply and divide units
  logic [W-1:0]  mul_r;
  logic          mul_sat;
  logic [NQ-1:0] quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  den;

  qalu_mul #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS),
    .LAT       (NQ)
  ) u_mul (
    .clk (clk),
    .en  (en),
    .x   (mag_a1),
    .y   (mag_b1),
    .neg (sb[0].neg),
    .res (mul_r),
    .sat (mul_sat)
  );

  qalu_div #(
    .WORD_BITS (W),
    .NQ        (NQ)
  ) u_div (
    .clk     (clk),
    .en      (en),
    .num     ({mag_a1, {FRAC_BITS{1'b0}}}),
    .den     (mag_b1),
    .quo     (quo),
    .rem     (rem),
    .den_out (den)
  );

  // divide rounding and result selection
  logic [NQ:0]         q_rnd;
  logic [NQ:0]         lim;
  logic                div_sat;
  logic [W-1:0]        div_mag;
  logic [W-1:0]        div_r;
  logic signed [W-1:0] r_full;
  out_item_t           out_next;

  always_comb begin
    q_rnd   = {1'b0, quo} + (NQ+1)'(rem >= (den - rem));
    lim     = ((NQ+1)'(1) << (W - 1)) - (NQ+1)'(!sb[NQ].neg);
    div_sat = q_rnd > lim;
    div_mag = div_sat ? lim[W-1:0] : q_rnd[W-1:0];
    div_r   = sb[NQ].neg ? (W'(0) - div_mag) : div_mag;
    out_next.compare_true = sb[NQ].cmp;
    out_next.status       = ST_OK;
    r_full                = sb[NQ].r;
    unique case (sb[NQ].op)
      OP_MUL: begin
        r_full = mul_r;
        out_next.status = mul_sat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (sb[NQ].bz) begin
          r_full = '0;
          out_next.status = ST_DIV0;
        end else begin
          r_full = div_r;
          out_next.status = div_sat ? ST_SAT : ST_OK;
        end
      end
      default: r_full = sb[NQ].r;
    endcase
    out_next.result_value = IO_BITS'(r_full);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= out_next;
  end

  // checks
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_DIV0 |->
      out_data.result_value == '0 && !out_data.compare_true)
    else $error("divide by zero result not cleared");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.compare_true |->
      out_data.status == ST_OK && out_data.result_value == '0)
    else $error("compare item carries value or status");

  a_tail_moves: assert property (@(posedge clk) disable iff (rst)
    v[NQ] && en |=> out_valid)
    else $error("item lost between pipeline tail and output register");

endmodule

// ===== design/qalu_mul.sv =====
// Pipelined magnitude multiplier with round-half-away and saturation.
// Uses qalu_pkg; the result is registered in each stage, then delayed by a register line sized from LAT.
module qalu_mul #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8,
  parameter int LAT       = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 sat
);
  import qalu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int PW = 2 * W;
  localparam int DL = LAT - 3;

  // stage 1: partial products
  logic [2*H-1:0] p_ll;
  logic [H+L-1:0] p_lh;
  logic [H+L-1:0] p_hl;
  logic [2*L-1:0] p_hh;
  logic           neg1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= (2*H)'(x[H-1:0]) * (2*H)'(y[H-1:0]);
      p_lh <= (H+L)'(x[H-1:0]) * (H+L)'(y[W-1:H]);
      p_hl <= (H+L)'(x[W-1:H]) * (H+L)'(y[H-1:0]);
      p_hh <= (2*L)'(x[W-1:H]) * (2*L)'(y[W-1:H]);
      neg1 <= neg;
    end
  end

  // stage 2: sum the partial products with the rounding half, drop fraction
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic          neg2;

  always_comb begin
    prod = (PW'(p_hh) << (2*H)) + (PW'(p_lh) << H) + (PW'(p_hl) << H) + PW'(p_ll)
         + (PW'(1) << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shifted <= prod >> FRAC_BITS;
      neg2    <= neg1;
    end
  end

  // stage 3: saturate and apply the sign
  logic [PW-1:0] lim;
  logic [W-1:0]  mag;
  logic [W-1:0]  res3_next;
  logic          sat3_next;

  always_comb begin
    lim = (PW'(1) << (W - 1)) - PW'(!neg2);
    sat3_next = shifted > lim;
    mag = sat3_next ? lim[W-1:0] : shifted[W-1:0];
    res3_next = neg2 ? (W'(0) - mag) : mag;
  end

  logic [W-1:0] res_d [DL+1];
  logic         sat_d [DL+1];

  always_ff @(posedge clk) begin
    if (en) begin
      res_d[0] <= res3_next;
      sat_d[0] <= sat3_next;
      for (int i = 1; i <= DL; i++) begin
        res_d[i] <= res_d[i-1];
        sat_d[i] <= sat_d[i-1];
      end
    end
  end

  assign res = res_d[DL];
  assign sat = sat_d[DL];

endmodule

// ===== design/qalu_div.sv =====
// Restoring divider, one quotient bit per pipeline stage.
// Uses qalu_pkg; quotient, remainder and divisor leave from the last stage.
module qalu_div #(
  parameter int WORD_BITS = 32,
  parameter int NQ        = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NQ-1:0]        num,
  input  logic [WORD_BITS-1:0] den,
  output logic [NQ-1:0]        quo,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] den_out
);
  import qalu_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0]  rem_s [NQ+1];
  logic [NQ-1:0] num_s [NQ+1];
  logic [NQ-1:0] quo_s [NQ+1];
  logic [W-1:0]  den_s [NQ+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  // one trial subtract per stage
  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic [W-1:0] t;
    logic         ge;

    always_comb begin
      t  = {rem_s[k][W-2:0], num_s[k][NQ-1]};
      ge = t >= den_s[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? (t - den_s[k]) : t;
        num_s[k+1] <= num_s[k] << 1;
        quo_s[k+1] <= {quo_s[k][NQ-2:0], ge};
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign quo     = quo_s[NQ];
  assign rem     = rem_s[NQ];
  assign den_out = den_s[NQ];

endmodule
